@@ rtl/gvg_pkg.sv @@
// types, codes and constants of the gas leak valve guard
// no dependencies; imported by every module of the block
`default_nettype none

package gvg_pkg;

    localparam int unsigned PRESS_W = 12;
    localparam int unsigned HITS_W  = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned ALARM_W = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [HITS_W-1:0]  FLAME_READS      = 4'd10;
    localparam logic [CNT_W-1:0]   CNT_MAX          = 4'd15;
    localparam logic [ALARM_W-1:0] ALARM_TEST_MS    = 11'd800;
    localparam logic [ALARM_W-1:0] ALARM_SHUTOFF_MS = 11'd1200;
    localparam logic [ALARM_W-1:0] ALARM_NONE       = 11'd0;

    typedef enum logic [2:0] {
        CMD_SAMPLE   = 3'd0,
        CMD_OPEN     = 3'd1,
        CMD_CLOSE    = 3'd2,
        CMD_TEST     = 3'd3,
        CMD_SHUTOFF  = 3'd4,
        CMD_RESET    = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STABLE    = 3'd1,
        EV_HELD      = 3'd2,
        EV_COOKING   = 3'd3,
        EV_DROP_WARN = 3'd4,
        EV_LEAK      = 3'd5,
        EV_LOW       = 3'd6,
        EV_LOCKED    = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        ST_SAFE     = 2'd0,
        ST_WARNING  = 2'd1,
        ST_CRITICAL = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_THR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_CONFIRM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLAME_NEED   = 3'd4;

    typedef struct packed {
        logic [PRESS_W-1:0] drop_thr;
        logic [PRESS_W-1:0] low_level;
        logic [HOLD_W-1:0]  holdoff_ms;
        logic [CNT_W-1:0]   leak_confirm;
        logic [HITS_W-1:0]  flame_need;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [HITS_W-1:0]  flame_hits;
        logic [PRESS_W-1:0] pressure;
        t_cmd               cmd;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]   drop_count;
        logic [PRESS_W-1:0] peak_level;
        logic [ALARM_W-1:0] alarm_ms;
        logic               event_new;
        t_event             event_res;
        t_status            status;
        logic               latched;
        logic               valve_open;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/gas_leak_valve_guard.sv @@
// gas leak valve guard: input request register, decision stage, result register
// a request passes from the request register through the decision stage into the result register;
// one request per cycle sustained unless i_m_tready stalls the result; single decision stage between the registers
// synchronous active-low reset: valve open, latch clear, peak and counters zero,
// configuration at defaults, both registers empty
// depends on gvg_pkg, gvg_cfg, gvg_eval
`default_nettype none

module gas_leak_valve_guard (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // cmd [2:0]
    input  wire logic [2:0]                    i_s_tuser,
    // pressure [11:0], flame_hits [15:12], time_ms [47:16]
    input  wire logic [47:0]                   i_s_tdata,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // valve_open [0], latched [1], status [3:2], event_res [6:4], event_new [7],
    // alarm_ms [18:8], peak_level [30:19], drop_count [34:31], zero [39:35]
    output logic [39:0]                        o_m_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic                          i_cfg_we,
    input  wire logic [gvg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gvg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import gvg_pkg::*;

    t_cfg cfg;
    t_req r_req;
    logic r_req_vld;
    t_res res;
    t_res r_res;
    logic r_res_vld;
    logic go;

    assign go         = r_req_vld && (!r_res_vld || i_m_tready);
    assign o_s_tready = !r_req_vld || go;

    gvg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gvg_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (r_req),
        .i_go    (go),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (o_s_tready) r_req_vld <= i_s_tvalid;
            if (go) r_res_vld <= 1'b1;
            else if (i_m_tready) r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_req.cmd        <= t_cmd'(i_s_tuser);
            r_req.pressure   <= i_s_tdata[11:0];
            r_req.flame_hits <= i_s_tdata[15:12];
            r_req.time_ms    <= i_s_tdata[47:16];
        end
        if (go) r_res <= res;
    end

    assign o_m_tvalid = r_res_vld;
    assign o_m_tdata  = {5'd0, r_res};

endmodule

`default_nettype wire

@@ rtl/gvg_cfg.sv @@
// configuration register file of the valve guard
// depends on gvg_pkg
`default_nettype none

module gvg_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gvg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gvg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output gvg_pkg::t_cfg                      o_cfg
);
    import gvg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_thr     <= 12'd35;
            r_cfg.low_level    <= 12'd372;
            r_cfg.holdoff_ms   <= 16'd15000;
            r_cfg.leak_confirm <= 4'd2;
            r_cfg.flame_need   <= 4'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DROP_THR:     r_cfg.drop_thr     <= i_cfg_wdata[PRESS_W-1:0];
                REG_LOW_LEVEL:    r_cfg.low_level    <= i_cfg_wdata[PRESS_W-1:0];
                REG_HOLDOFF:      r_cfg.holdoff_ms   <= i_cfg_wdata[HOLD_W-1:0];
                REG_LEAK_CONFIRM: r_cfg.leak_confirm <= i_cfg_wdata[CNT_W-1:0];
                REG_FLAME_NEED:   r_cfg.flame_need   <= i_cfg_wdata[HITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/gvg_eval.sv @@
// guard state and per-request decision logic
// depends on gvg_pkg; state advances when i_go is high
`default_nettype none

module gvg_eval (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gvg_pkg::t_cfg  i_cfg,
    input  wire gvg_pkg::t_req  i_req,
    input  wire logic           i_go,
    output gvg_pkg::t_res       o_res
);
    import gvg_pkg::*;

    logic [PRESS_W-1:0] r_peak,  n_peak;
    logic               r_latch, n_latch;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_valve, n_valve;
    logic               r_hold,  n_hold;
    logic [TIME_W-1:0]  r_until, n_until;
    t_event             r_last,  n_last;

    logic [HITS_W-1:0]  hits;
    logic [PRESS_W-1:0] peak_up;
    logic [CNT_W-1:0]   cnt_inc;
    logic               flame, dropping, low, in_hold;
    t_status            status;
    t_event             ev;
    logic               ev_new;
    logic [ALARM_W-1:0] alarm;

    always_comb begin
        hits     = (i_req.flame_hits > FLAME_READS) ? FLAME_READS : i_req.flame_hits;
        flame    = hits >= i_cfg.flame_need;
        peak_up  = (i_req.pressure > r_peak) ? i_req.pressure : r_peak;
        dropping = (peak_up - i_req.pressure) >= i_cfg.drop_thr;
        low      = i_req.pressure < i_cfg.low_level;
        in_hold  = i_req.time_ms < r_until;
        cnt_inc  = (r_cnt < CNT_MAX) ? r_cnt + 4'd1 : r_cnt;

        n_peak  = r_peak;
        n_latch = r_latch;
        n_cnt   = r_cnt;
        n_valve = r_valve;
        n_hold  = r_hold;
        n_until = r_until;
        n_last  = r_last;
        status  = ST_SAFE;
        ev      = EV_NONE;
        ev_new  = 1'b0;
        alarm   = ALARM_NONE;

        case (i_req.cmd)
            CMD_SAMPLE: begin
                if (r_latch) begin
                    n_valve = 1'b0;
                    ev      = EV_LOCKED;
                    status  = ST_CRITICAL;
                end else begin
                    n_peak = peak_up;
                    if (low && !in_hold) begin
                        n_valve = 1'b0;
                        n_latch = 1'b1;
                        ev      = EV_LOW;
                        status  = ST_CRITICAL;
                    end else if (dropping && !flame && !in_hold) begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.leak_confirm) begin
                            n_valve = 1'b0;
                            n_latch = 1'b1;
                            ev      = EV_LEAK;
                            status  = ST_CRITICAL;
                        end else begin
                            if (r_hold) n_valve = 1'b0;
                            ev     = EV_DROP_WARN;
                            status = ST_WARNING;
                        end
                    end else if (dropping && flame) begin
                        n_cnt   = '0;
                        n_peak  = i_req.pressure;
                        n_valve = !r_hold;
                        ev      = EV_COOKING;
                    end else begin
                        n_cnt   = '0;
                        n_valve = !r_hold;
                        ev      = r_hold ? EV_HELD : EV_STABLE;
                    end
                end
                ev_new = ev != r_last;
                n_last = ev;
            end
            CMD_OPEN: begin
                n_hold = 1'b0;
                if (!r_latch) n_valve = 1'b1;
            end
            CMD_CLOSE: begin
                n_hold  = 1'b1;
                n_valve = 1'b0;
            end
            CMD_TEST: begin
                alarm = ALARM_TEST_MS;
            end
            CMD_SHUTOFF: begin
                n_hold  = 1'b0;
                n_valve = 1'b0;
                n_latch = 1'b1;
                alarm   = ALARM_SHUTOFF_MS;
            end
            CMD_RESET: begin
                n_latch = 1'b0;
                n_hold  = 1'b0;
                n_cnt   = '0;
                n_peak  = i_req.pressure;
                n_last  = EV_NONE;
                n_until = i_req.time_ms + {{(TIME_W-HOLD_W){1'b0}}, i_cfg.holdoff_ms};
                n_valve = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_latch <= 1'b0;
            r_cnt   <= '0;
            r_valve <= 1'b1;
            r_hold  <= 1'b0;
            r_until <= '0;
            r_last  <= EV_NONE;
        end else if (i_go) begin
            r_peak  <= n_peak;
            r_latch <= n_latch;
            r_cnt   <= n_cnt;
            r_valve <= n_valve;
            r_hold  <= n_hold;
            r_until <= n_until;
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_res.valve_open = n_valve;
        o_res.latched    = n_latch;
        o_res.status     = status;
        o_res.event_res  = ev;
        o_res.event_new  = ev_new;
        o_res.alarm_ms   = alarm;
        o_res.peak_level = n_peak;
        o_res.drop_count = n_cnt;
    end

endmodule

`default_nettype wire

@@ verif/gvg_guard_checker.sv @@
`timescale 1ns / 100ps
// result checker for the gas leak valve guard: watches the request, result and register ports,
// predicts each result from its own copy of the guard state and compares it field by field
// depends on gvg_pkg

module gvg_guard_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // cmd [2:0]
    input  wire logic [2:0]                     i_s_tuser,
    // pressure [11:0], flame_hits [15:12], time_ms [47:16]
    input  wire logic [47:0]                    i_s_tdata,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // valve_open [0], latched [1], status [3:2], event_res [6:4], event_new [7],
    // alarm_ms [18:8], peak_level [30:19], drop_count [34:31], zero [39:35]
    input  wire logic [39:0]                    i_m_tdata,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic                           i_cfg_we,
    input  wire logic [gvg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gvg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import gvg_pkg::*;

    t_cfg               guard_cfg;
    logic [PRESS_W-1:0] peak;
    logic               latch;
    logic               valve;
    logic               manual_hold;
    logic [CNT_W-1:0]   drops;
    logic [TIME_W-1:0]  hold_until;
    t_event             last_ev;
    t_res               outcomes[$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 50) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic t_res next_outcome(input logic [2:0] cmd, input logic [PRESS_W-1:0] p,
                                          input logic [HITS_W-1:0] hits_in,
                                          input logic [TIME_W-1:0] now);
        t_res              r;
        logic [HITS_W-1:0] hits;
        logic              flame;
        logic              dropping;
        logic              low_p;
        logic              in_hold;
        r = '0;
        hits = (hits_in > FLAME_READS) ? FLAME_READS : hits_in;
        case (cmd)
            CMD_SAMPLE: begin
                if (latch) begin
                    valve = 1'b0;
                    r.event_res = EV_LOCKED;
                    r.status = ST_CRITICAL;
                end else begin
                    flame = hits >= guard_cfg.flame_need;
                    if (p > peak) peak = p;
                    dropping = (peak - p) >= guard_cfg.drop_thr;
                    low_p = p < guard_cfg.low_level;
                    in_hold = now < hold_until;
                    if (low_p && !in_hold) begin
                        valve = 1'b0;
                        latch = 1'b1;
                        r.event_res = EV_LOW;
                        r.status = ST_CRITICAL;
                    end else if (dropping && !flame && !in_hold) begin
                        if (drops < CNT_MAX) drops = drops + 1'b1;
                        if (drops >= guard_cfg.leak_confirm) begin
                            valve = 1'b0;
                            latch = 1'b1;
                            r.event_res = EV_LEAK;
                            r.status = ST_CRITICAL;
                        end else begin
                            if (manual_hold) valve = 1'b0;
                            r.event_res = EV_DROP_WARN;
                            r.status = ST_WARNING;
                        end
                    end else if (dropping && flame) begin
                        drops = '0;
                        peak = p;
                        valve = !manual_hold;
                        r.event_res = EV_COOKING;
                    end else begin
                        drops = '0;
                        valve = !manual_hold;
                        r.event_res = manual_hold ? EV_HELD : EV_STABLE;
                    end
                end
                r.event_new = (r.event_res != last_ev);
                last_ev = r.event_res;
            end
            CMD_OPEN: begin
                manual_hold = 1'b0;
                if (!latch) valve = 1'b1;
            end
            CMD_CLOSE: begin
                manual_hold = 1'b1;
                valve = 1'b0;
            end
            CMD_TEST: begin
                r.alarm_ms = ALARM_TEST_MS;
            end
            CMD_SHUTOFF: begin
                manual_hold = 1'b0;
                valve = 1'b0;
                latch = 1'b1;
                r.alarm_ms = ALARM_SHUTOFF_MS;
            end
            CMD_RESET: begin
                latch = 1'b0;
                manual_hold = 1'b0;
                drops = '0;
                peak = p;
                last_ev = EV_NONE;
                hold_until = now + TIME_W'(guard_cfg.holdoff_ms);
                valve = 1'b1;
            end
            default: ;
        endcase
        r.valve_open = valve;
        r.latched = latch;
        r.peak_level = peak;
        r.drop_count = drops;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            guard_cfg = '{12'd35, 12'd372, 16'd15000, 4'd2, 4'd5};
            peak = '0;
            latch = 1'b0;
            valve = 1'b1;
            manual_hold = 1'b0;
            drops = '0;
            hold_until = '0;
            last_ev = EV_NONE;
            outcomes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_res'(i_m_tdata[34:0]);
                if (outcomes.size() == 0) begin
                    report_mismatch($sformatf("result 0x%h with no request waiting", i_m_tdata));
                end else begin
                    want = outcomes.pop_front();
                    check_field("valve_open", got.valve_open, want.valve_open);
                    check_field("latched", got.latched, want.latched);
                    check_field("status", got.status, want.status);
                    check_field("event_res", got.event_res, want.event_res);
                    check_field("event_new", got.event_new, want.event_new);
                    check_field("alarm_ms", got.alarm_ms, want.alarm_ms);
                    check_field("peak_level", got.peak_level, want.peak_level);
                    check_field("drop_count", got.drop_count, want.drop_count);
                    check_field("padding", i_m_tdata[39:35], '0);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DROP_THR:     guard_cfg.drop_thr = i_cfg_wdata[PRESS_W-1:0];
                    REG_LOW_LEVEL:    guard_cfg.low_level = i_cfg_wdata[PRESS_W-1:0];
                    REG_HOLDOFF:      guard_cfg.holdoff_ms = i_cfg_wdata[HOLD_W-1:0];
                    REG_LEAK_CONFIRM: guard_cfg.leak_confirm = i_cfg_wdata[CNT_W-1:0];
                    REG_FLAME_NEED:   guard_cfg.flame_need = i_cfg_wdata[HITS_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                outcomes.push_back(next_outcome(i_s_tuser, i_s_tdata[11:0], i_s_tdata[15:12],
                                                i_s_tdata[47:16]));
            end
        end
        o_pending <= outcomes.size();
    end

endmodule

@@ verif/gas_leak_valve_guard_test.sv @@
`timescale 1ns / 100ps
// top of the gas leak valve guard testbench: clock, reset, register settings, request and
// result handshakes and the verdict; depends on gvg_pkg, gas_leak_valve_guard, gvg_guard_checker

module gas_leak_valve_guard_test;
    import gvg_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SEG_ITEMS = 285;
    localparam int DRAIN_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    // cmd [2:0]
    logic [2:0]            i_s_tuser = '0;
    // pressure [11:0], flame_hits [15:12], time_ms [47:16]
    logic [47:0]           i_s_tdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire  [39:0]           o_m_tdata;

    int          fail_count;
    int          pending_count;
    int          tx_idle_pct = 29;
    int          rx_idle_pct = 67;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          req_count = 0;
    int          setting_count = 0;
    bit          drain_stuck = 1'b0;
    logic [31:0] now_ms;
    t_cfg        cur_cfg;

    gas_leak_valve_guard i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    gvg_guard_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tuser    (i_s_tuser),
        .i_s_tdata    (i_s_tdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic push_req(input logic [2:0] cmd, input logic [11:0] p, input logic [3:0] hits,
                            input logic [31:0] t);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {t, hits, p};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        req_count++;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending_count != 0 && n < DRAIN_LIMIT);
        if (pending_count != 0) drain_stuck = 1'b1;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic write_setting(input t_cfg c);
        reg_write(REG_DROP_THR, CFG_DATA_W'(c.drop_thr));
        reg_write(REG_LOW_LEVEL, CFG_DATA_W'(c.low_level));
        reg_write(REG_HOLDOFF, c.holdoff_ms);
        reg_write(REG_LEAK_CONFIRM, CFG_DATA_W'(c.leak_confirm));
        reg_write(REG_FLAME_NEED, CFG_DATA_W'(c.flame_need));
        i_cfg_we <= 1'b0;
        cur_cfg = c;
        setting_count++;
    endtask

    // runs of samples around a base level, most started by a reset, with commands and noise mixed in
    task automatic run_segment(input int n_items, input bit do_long_hold);
        int          k;
        int          r;
        int          len;
        int          v;
        bit          paused;
        logic [11:0] base;
        k = 0;
        paused = 1'b0;
        while (k < n_items) begin
            base = 12'($urandom_range(4095, 200));
            if ($urandom_range(9) != 0) begin
                now_ms += $urandom_range(5000);
                push_req(CMD_RESET, base, 4'($urandom), now_ms);
                k++;
            end
            len = $urandom_range(30, 3);
            repeat (len) begin
                r = $urandom_range(99);
                if ($urandom_range(31) == 0) now_ms = $urandom;
                else now_ms += $urandom_range(2500);
                if (r < 8) begin
                    push_req(3'($urandom), 12'($urandom), 4'($urandom), $urandom);
                end else if (r < 20) begin
                    push_req(3'($urandom_range(4, 1)), 12'($urandom), 4'($urandom), now_ms);
                end else begin
                    if (r < 28) v = int'(cur_cfg.low_level) + $urandom_range(8) - 4;
                    else if (r < 34) v = int'(base) + $urandom_range(200);
                    else v = int'(base) - $urandom_range(2 * int'(cur_cfg.drop_thr) + 4);
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                    push_req(CMD_SAMPLE, 12'(v), 4'($urandom_range(15)), now_ms);
                end
                k++;
                if (do_long_hold && k == n_items / 3) long_hold_req = 1'b1;
                if (!paused && k >= n_items / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end
    endtask

    initial begin
        t_cfg c;
        cur_cfg = '{12'd35, 12'd372, 16'd15000, 4'd2, 4'd5};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // peak tracking, drop warning, cooking, flame clamp
        push_req(CMD_SAMPLE, 12'd2000, 4'd0, 32'd1000);
        push_req(CMD_SAMPLE, 12'd2000, 4'd0, 32'd1010);
        push_req(CMD_SAMPLE, 12'd1960, 4'd0, 32'd1020);
        push_req(CMD_SAMPLE, 12'd1960, 4'd10, 32'd1030);
        push_req(CMD_SAMPLE, 12'd4095, 4'd15, 32'd1040);
        // manual hold, drop warning with valve held, leak, lockout
        push_req(CMD_OPEN, 12'd0, 4'd0, 32'd1050);
        push_req(CMD_CLOSE, 12'd0, 4'd0, 32'd1060);
        push_req(CMD_SAMPLE, 12'd4095, 4'd0, 32'd1070);
        push_req(CMD_SAMPLE, 12'd4000, 4'd0, 32'd1080);
        push_req(CMD_SAMPLE, 12'd4000, 4'd0, 32'd1090);
        push_req(CMD_SAMPLE, 12'd4000, 4'd0, 32'd1100);
        push_req(CMD_OPEN, 12'd0, 4'd0, 32'd1110);
        push_req(CMD_TEST, 12'd0, 4'd0, 32'd1120);
        // holdoff window and its exact end
        push_req(CMD_RESET, 12'd3000, 4'd0, 32'd20000);
        push_req(CMD_SAMPLE, 12'd100, 4'd0, 32'd20100);
        push_req(CMD_SAMPLE, 12'd2900, 4'd0, 32'd34999);
        push_req(CMD_SAMPLE, 12'd0, 4'd0, 32'd35000);
        push_req(CMD_SPARE6, 12'd4095, 4'd15, 32'hFFFF_FFFF);
        push_req(CMD_SPARE7, 12'd0, 4'd0, 32'd0);
        push_req(CMD_SHUTOFF, 12'd0, 4'd0, 32'd36000);
        // holdoff end that wraps past the top of the time range
        push_req(CMD_RESET, 12'd4095, 4'd0, 32'hFFFF_F000);
        push_req(CMD_SAMPLE, 12'd4095, 4'd0, 32'hFFFF_FFFF);
        push_req(CMD_SAMPLE, 12'd0, 4'd0, 32'hFFFF_FFFF);
        push_req(CMD_RESET, 12'd0, 4'd0, 32'd0);
        push_req(CMD_SAMPLE, 12'd4095, 4'd10, 32'd0);
        wait_drained();

        now_ms = 32'd0;
        for (int seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                tx_idle_pct = 29;
                rx_idle_pct = 67;
            end else if (seg < 4) begin
                tx_idle_pct = 67;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0: c = '{12'd35, 12'd372, 16'd15000, 4'd2, 4'd5};
                1: c = '{12'd1, 12'd0, 16'd0, 4'd1, 4'd1};
                2: c = '{12'd4095, 12'd4095, 16'd65535, 4'd15, 4'd10};
                3: c = '{12'd20, 12'd200, 16'd3000, 4'd0, 4'd15};
                4: c = '{12'd50, 12'd300, 16'd2000, 4'd15, 4'd3};
                default: c = '{12'($urandom_range(4095, 1)), 12'($urandom), 16'($urandom),
                               4'($urandom_range(15, 1)), 4'($urandom_range(10, 1))};
            endcase
            write_setting(c);
            run_segment(SEG_ITEMS, seg == 4);
            wait_drained();
        end

        $display("run covered %0d requests with %0d register settings under three handshake modes,",
                 req_count, setting_count);
        $display("with a long output stall and drained pauses of the request stream");
        if (fail_count == 0 && !drain_stuck) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gvg_pkg.sv
rtl/gvg_cfg.sv
rtl/gvg_eval.sv
rtl/gas_leak_valve_guard.sv
verif/gvg_guard_checker.sv
verif/gas_leak_valve_guard_test.sv
